### sv/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Shared widths, register indexes and types of the PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

	localparam int DATA_W  = 16;
	localparam int ERR_W   = DATA_W + 1;
	localparam int TOTAL_W = 32;
	localparam int IDX_W   = 3;
	localparam int FRAC_W  = 8;

	typedef enum logic [IDX_W-1:0] {
		REG_SETPOINT   = 3'd0,
		REG_GAIN_P     = 3'd1,
		REG_GAIN_I     = 3'd2,
		REG_GAIN_D     = 3'd3,
		REG_LIMIT_HIGH = 3'd4,
		REG_LIMIT_LOW  = 3'd5,
		REG_MODE       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] setpoint;
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic signed [DATA_W-1:0] limit_high;
		logic signed [DATA_W-1:0] limit_low;
		logic                     incremental_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]   error_prev;
		logic signed [ERR_W-1:0]   error_prev2;
		logic signed [TOTAL_W-1:0] error_total;
		logic signed [DATA_W-1:0]  drive_prev;
	} state_t;

endpackage

### sv/pid_if.sv
// ----------------------------------------------------------------------------
// pid_if
// Valid/ready channels of the PID controller: sample, result and register write.
// ----------------------------------------------------------------------------
interface pid_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [pid_pkg::DATA_W-1:0]  feedback;

	modport source (output valid, output feedback, input ready);
	modport sink   (input valid, input feedback, output ready);
endinterface

interface pid_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [pid_pkg::DATA_W-1:0]  drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface

interface pid_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pid_pkg::IDX_W-1:0]    index;
	logic [pid_pkg::DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/pid_controller.sv
// Stage s1 (valid_s1, feedback_s1) holds a sample; stage s2 (valid_s2, drive_s2) its drive.
// Throughput: one sample per cycle while the result side keeps ready high.
// The loop through error sum and previous drive closes through the state register st_q.
// Reset: arst_n clears history, error sum, valid flags and loads register defaults
// (gain_p 1.0, limits full scale, positional form).
// ----------------------------------------------------------------------------
// pid_controller
// Discrete PID controller, positional or incremental form, in Q8.8 fixed point.
// ----------------------------------------------------------------------------
module pid_controller (
	input  logic          clk,
	input  logic          arst_n,
	pid_sample_if.sink    sample,
	pid_result_if.source  result,
	pid_cfg_if.sink       cfg
);
	import pid_pkg::*;

	cfg_t                     regs;
	state_t                   st_q;
	state_t                   st_next;
	logic                     valid_s1;
	logic signed [DATA_W-1:0] feedback_s1;
	logic                     valid_s2;
	logic signed [DATA_W-1:0] drive_s2;
	logic signed [DATA_W-1:0] drive_comb;
	logic                     fire;

	pid_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pid_datapath u_dp (
		.regs     (regs),
		.feedback (feedback_s1),
		.st       (st_q),
		.st_next  (st_next),
		.drive    (drive_comb)
	);

	assign fire         = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || fire;
	assign result.valid = valid_s2;
	assign result.drive = drive_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (fire) begin
				valid_s2 <= 1'b1;
				st_q     <= st_next;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready)
			feedback_s1 <= sample.feedback;
		if (fire)
			drive_s2 <= drive_comb;
	end

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(st_q))
		else $error("controller state moved while result stalled");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> valid_s1)
		else $error("accepted sample not held in input stage");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(valid_s1))
		else $error("result appeared without a sample in the input stage");

endmodule

### sv/pid_cfg_regs.sv
// ----------------------------------------------------------------------------
// pid_cfg_regs
// Register bank for setpoint, gains, clamp limits and mode.
// ----------------------------------------------------------------------------
module pid_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	pid_cfg_if.sink       cfg,
	output pid_pkg::cfg_t regs
);
	import pid_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.setpoint         <= '0;
			regs_q.gain_p           <= DATA_W'(256);
			regs_q.gain_i           <= '0;
			regs_q.gain_d           <= '0;
			regs_q.limit_high       <= DATA_W'(32767);
			regs_q.limit_low        <= DATA_W'(-32768);
			regs_q.incremental_mode <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SETPOINT:   regs_q.setpoint         <= cfg.data;
				REG_GAIN_P:     regs_q.gain_p           <= cfg.data;
				REG_GAIN_I:     regs_q.gain_i           <= cfg.data;
				REG_GAIN_D:     regs_q.gain_d           <= cfg.data;
				REG_LIMIT_HIGH: regs_q.limit_high       <= cfg.data;
				REG_LIMIT_LOW:  regs_q.limit_low        <= cfg.data;
				REG_MODE:       regs_q.incremental_mode <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

### sv/pid_datapath.sv
// ----------------------------------------------------------------------------
// pid_datapath
// Error, saturating error sum, three gain products, scaling and clamp.
// ----------------------------------------------------------------------------
module pid_datapath (
	input  pid_pkg::cfg_t                     regs,
	input  logic signed [pid_pkg::DATA_W-1:0] feedback,
	input  pid_pkg::state_t                   st,
	output pid_pkg::state_t                   st_next,
	output logic signed [pid_pkg::DATA_W-1:0] drive
);
	import pid_pkg::*;

	localparam int D1_W  = ERR_W + 1;
	localparam int D2_W  = ERR_W + 2;
	localparam int PA_W  = DATA_W + D1_W;
	localparam int PB_W  = DATA_W + TOTAL_W;
	localparam int PC_W  = DATA_W + D2_W;
	localparam int ACC_W = PB_W + 2;
	localparam int SH_W  = ACC_W - FRAC_W;
	localparam int Y_W   = SH_W + 1;

	logic signed [ERR_W-1:0]   e;
	logic signed [D1_W-1:0]    d1;
	logic signed [D2_W-1:0]    d2;
	logic signed [TOTAL_W:0]   sum_wide;
	logic signed [TOTAL_W-1:0] total_next;
	logic signed [D1_W-1:0]    op_a;
	logic signed [TOTAL_W-1:0] op_b;
	logic signed [D2_W-1:0]    op_c;
	logic signed [PA_W-1:0]    prod_a;
	logic signed [PB_W-1:0]    prod_b;
	logic signed [PC_W-1:0]    prod_c;
	logic signed [ACC_W-1:0]   acc;
	logic signed [SH_W-1:0]    scaled;
	logic signed [Y_W-1:0]     y_raw;
	logic signed [Y_W-1:0]     lim_hi;
	logic signed [Y_W-1:0]     lim_lo;
	logic signed [Y_W-1:0]     y_clamped;

	always_comb begin
		e  = ERR_W'(regs.setpoint) - ERR_W'(feedback);
		d1 = D1_W'(e) - D1_W'(st.error_prev);
		d2 = D2_W'(e) - (D2_W'(st.error_prev) <<< 1) + D2_W'(st.error_prev2);

		sum_wide = (TOTAL_W+1)'(st.error_total) + (TOTAL_W+1)'(e);
		if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1])
			total_next = sum_wide[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
			                               : {1'b0, {(TOTAL_W-1){1'b1}}};
		else
			total_next = sum_wide[TOTAL_W-1:0];

		if (regs.incremental_mode) begin
			op_a = d1;
			op_b = TOTAL_W'(e);
			op_c = d2;
		end else begin
			op_a = D1_W'(e);
			op_b = total_next;
			op_c = D2_W'(d1);
		end

		prod_a = regs.gain_p * op_a;
		prod_b = regs.gain_i * op_b;
		prod_c = regs.gain_d * op_c;
		acc    = ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(prod_c);
		scaled = SH_W'(acc >>> FRAC_W);

		y_raw = Y_W'(scaled);
		if (regs.incremental_mode)
			y_raw = Y_W'(scaled) + Y_W'(st.drive_prev);

		lim_hi    = Y_W'(regs.limit_high);
		lim_lo    = Y_W'(regs.limit_low);
		y_clamped = y_raw;
		if (y_clamped > lim_hi)
			y_clamped = lim_hi;
		if (y_clamped < lim_lo)
			y_clamped = lim_lo;
		drive = DATA_W'(y_clamped);

		st_next.error_prev  = e;
		st_next.error_prev2 = regs.incremental_mode ? st.error_prev : st.error_prev2;
		st_next.error_total = total_next;
		st_next.drive_prev  = drive;
	end

endmodule

### sim/pid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_checker
// Monitors the register write, sample and result channels of the PID controller.
// It keeps its own copy of the registers and control history, works out the
// drive for each accepted sample, and compares it with the drive transfers in
// order. The failure count and the number of outstanding drives go to the top.
// ----------------------------------------------------------------------------
module pid_checker (
	input  logic        clk,
	input  logic        arst_n,
	pid_sample_if       sample,
	pid_result_if       result,
	pid_cfg_if          cfg,
	output int unsigned fail_count,
	output int unsigned pending
);

	import pid_pkg::*;

	localparam longint TOTAL_MAX   = (longint'(1) <<< (TOTAL_W - 1)) - 1;
	localparam longint TOTAL_MIN   = -(longint'(1) <<< (TOTAL_W - 1));

	cfg_t                     regs;
	state_t                   hist;
	logic signed [DATA_W-1:0] expected_drive[$];
	logic signed [DATA_W-1:0] want;

	task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] got,
			input logic signed [DATA_W-1:0] exp_val);
		fail_count++;
		$display("%0t: %s: drive %0d, predicted %0d", $realtime, what, got, exp_val);
	endtask

	function automatic logic signed [DATA_W-1:0] predict_drive(
			input logic signed [DATA_W-1:0] fb);
		longint err, prev, prev2, total, acc, y;
		err   = longint'($signed(regs.setpoint)) - longint'(fb);
		prev  = longint'($signed(hist.error_prev));
		prev2 = longint'($signed(hist.error_prev2));
		total = longint'($signed(hist.error_total)) + err;
		if (total > TOTAL_MAX)
			total = TOTAL_MAX;
		if (total < TOTAL_MIN)
			total = TOTAL_MIN;
		if (regs.incremental_mode) begin
			acc = longint'($signed(regs.gain_p)) * (err - prev)
				+ longint'($signed(regs.gain_i)) * err
				+ longint'($signed(regs.gain_d)) * (err - 2 * prev + prev2);
			y = longint'($signed(hist.drive_prev)) + (acc >>> FRAC_W);
			hist.error_prev2 = hist.error_prev;
		end else begin
			acc = longint'($signed(regs.gain_p)) * err
				+ longint'($signed(regs.gain_i)) * total
				+ longint'($signed(regs.gain_d)) * (err - prev);
			y = acc >>> FRAC_W;
		end
		hist.error_prev  = err[ERR_W-1:0];
		hist.error_total = total[TOTAL_W-1:0];
		// upper clamp first, so crossed limits give limit_low
		if (y > longint'($signed(regs.limit_high)))
			y = longint'($signed(regs.limit_high));
		if (y < longint'($signed(regs.limit_low)))
			y = longint'($signed(regs.limit_low));
		hist.drive_prev = y[DATA_W-1:0];
		return y[DATA_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.setpoint         = '0;
			regs.gain_p           = 16'sd256;
			regs.gain_i           = '0;
			regs.gain_d           = '0;
			regs.limit_high       = 16'sh7FFF;
			regs.limit_low        = 16'sh8000;
			regs.incremental_mode = 1'b0;
			hist                  = '0;
			expected_drive.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SETPOINT:   regs.setpoint = cfg.data;
					REG_GAIN_P:     regs.gain_p = cfg.data;
					REG_GAIN_I:     regs.gain_i = cfg.data;
					REG_GAIN_D:     regs.gain_d = cfg.data;
					REG_LIMIT_HIGH: regs.limit_high = cfg.data;
					REG_LIMIT_LOW:  regs.limit_low = cfg.data;
					REG_MODE:       regs.incremental_mode = cfg.data[0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_drive.size() == 0) begin
					report_mismatch("drive transfer with none outstanding", result.drive, '0);
				end else begin
					want = expected_drive.pop_front();
					if (result.drive !== want)
						report_mismatch("drive value", result.drive, want);
				end
			end
			if (sample.valid && sample.ready)
				expected_drive.push_back(predict_drive(sample.feedback));
			pending <= expected_drive.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the PID controller.
// Directed samples at the field extremes, gain extremes, crossed limits and
// mode switches, then random register settings with random feedback under
// several idle and stall profiles.
// ----------------------------------------------------------------------------
module testbench;

	import pid_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED     = 3'd7;
	localparam int unsigned      WATCHDOG_LIMIT = 2000;
	localparam int               RAND_PHASES    = 8;
	localparam int               PHASE_SAMPLES  = 50;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned quiet_cycles;
	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;

	pid_sample_if smp_ch();
	pid_result_if res_ch();
	pid_cfg_if    cfg_ch();

	pid_controller u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	pid_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (smp_ch),
		.result     (res_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("pid_controller: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic feed_sample(input logic signed [DATA_W-1:0] fb);
		while ($urandom_range(99) < src_idle_pct) begin
			smp_ch.valid <= 1'b0;
			@(negedge clk);
		end
		smp_ch.valid    <= 1'b1;
		smp_ch.feedback <= fb;
		do @(posedge clk); while (!smp_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		smp_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic set_idling(input int unsigned src, input int unsigned snk);
		src_idle_pct  = src;
		snk_stall_pct = snk;
	endtask

	function automatic logic [DATA_W-1:0] pick_gain();
		logic [DATA_W-1:0] g;
		case ($urandom_range(7))
			0, 1: g = DATA_W'($urandom);
			2: g = $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: begin
				g = DATA_W'($urandom_range(1024));
				g = g - 16'd512;
			end
		endcase
		return g;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_feedback(
			input logic signed [DATA_W-1:0] sp, input logic signed [DATA_W-1:0] last);
		logic signed [DATA_W-1:0] fb;
		int                       t;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: fb = DATA_W'($urandom);
			5, 6, 7: begin
				// small error around the setpoint
				t = int'(sp) + int'($urandom_range(600)) - 300;
				if (t > 32767)
					t = 32767;
				if (t < -32768)
					t = -32768;
				fb = t[DATA_W-1:0];
			end
			8: fb = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: fb = last;
		endcase
		return fb;
	endfunction

	initial begin
		int                       ph;
		logic signed [DATA_W-1:0] sp;
		logic signed [DATA_W-1:0] fb;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] hi;
		logic signed [DATA_W-1:0] lo;

		smp_ch.valid    = 1'b0;
		smp_ch.feedback = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		fb              = '0;
		set_idling(22, 22);
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: unity proportional gain, full-scale limits
		feed_sample(16'sh0000);
		feed_sample(16'sh8000);
		feed_sample(16'sh7FFF);
		feed_sample(-16'sd1);
		feed_sample(16'sd1);
		feed_sample(16'sh5555);
		feed_sample(16'shAAAA);
		drain_results();

		// gain extremes
		write_reg(REG_SETPOINT, 16'h7FFF);
		write_reg(REG_GAIN_P, 16'h8000);
		write_reg(REG_GAIN_I, 16'h7FFF);
		write_reg(REG_GAIN_D, 16'h8000);
		feed_sample(16'sh8000);
		feed_sample(16'sh7FFF);
		feed_sample(16'sh8000);
		drain_results();

		// crossed limits
		write_reg(REG_GAIN_P, 16'd256);
		write_reg(REG_LIMIT_HIGH, 16'h8000);
		write_reg(REG_LIMIT_LOW, 16'h7FFF);
		feed_sample(16'sh0000);
		feed_sample(16'sh7FFF);
		drain_results();

		// positional to incremental with history carried over
		write_reg(REG_LIMIT_HIGH, 16'h7FFF);
		write_reg(REG_LIMIT_LOW, 16'h8000);
		write_reg(REG_SETPOINT, 16'd1000);
		write_reg(REG_GAIN_I, 16'd128);
		write_reg(REG_GAIN_D, 16'd64);
		write_reg(REG_MODE, 16'd1);
		feed_sample(16'sd0);
		feed_sample(16'sd500);
		feed_sample(16'sd2000);
		feed_sample(16'sh8000);
		drain_results();

		// write to an index with no register, then back to positional
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_MODE, 16'd0);
		feed_sample(16'sd900);
		feed_sample(16'sd1100);
		drain_results();

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph % 4)
				0: set_idling(0, 0);
				1: set_idling(85, 0);
				2: set_idling(0, 85);
				default: set_idling(22, 22);
			endcase
			if (ph % 2 == 0) begin
				sp = DATA_W'($urandom);
			end else begin
				sp = DATA_W'($urandom_range(2000));
				sp = sp - 16'sd1000;
			end
			write_reg(REG_SETPOINT, sp);
			write_reg(REG_GAIN_P, pick_gain());
			write_reg(REG_GAIN_I, pick_gain());
			write_reg(REG_GAIN_D, pick_gain());
			a = DATA_W'($urandom);
			b = DATA_W'($urandom);
			if (a > b) begin
				hi = a;
				lo = b;
			end else begin
				hi = b;
				lo = a;
			end
			if ($urandom_range(5) == 0) begin
				a  = hi;
				hi = lo;
				lo = a;
			end else if ($urandom_range(3) == 0) begin
				hi = 16'sh7FFF;
				lo = 16'sh8000;
			end
			write_reg(REG_LIMIT_HIGH, hi);
			write_reg(REG_LIMIT_LOW, lo);
			write_reg(REG_MODE, DATA_W'($urandom_range(1)));
			repeat (PHASE_SAMPLES) begin
				fb = pick_feedback(sp, fb);
				feed_sample(fb);
			end
			drain_results();
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("pid_controller: match");
		else
			$display("pid_controller: mismatch");
		$finish;
	end

endmodule
